[hw/rtl/tcbs_pkg.sv]
// Package for turbo code block segmentation: constants, types, size table functions.
`default_nettype none

package tcbs_pkg;

    // Segmentation constants
    localparam int CRC_BITS      = 24;
    localparam int MAX_BLOCK_LEN = 6144;
    localparam int SEG_LEN       = MAX_BLOCK_LEN - CRC_BITS;
    localparam int TABLE_ENTRIES = 188;

    // Field and datapath widths
    localparam int TBS_W   = 20;
    localparam int CNT_W   = 8;
    localparam int SIZE_W  = 13;
    localparam int IDX_W   = 8;
    localparam int FILL_W  = 6;
    localparam int NUM_W   = 21;   // B, B' and C*K+ fit in 21 bits
    localparam int STEP_W  = 4;    // divider step count, up to SIZE_W
    localparam int SHAMT_W = 5;    // shift amount over NUM_W

    // Interleaver size table regions: step 8, 16, 32, 64
    localparam int REG16_START = 60;
    localparam int REG32_START = 92;
    localparam int REG64_START = 124;
    localparam int REG16_BASE  = 528;
    localparam int REG32_BASE  = 1056;
    localparam int REG64_BASE  = 2112;
    localparam int REG8_BASE   = 40;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_C,
        ST_BP,
        ST_DIV_K,
        ST_SEARCH,
        ST_MULT,
        ST_DIFF,
        ST_DONE
    } state_t;

    // Divider control and status
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Interleaver size K for a table index (piecewise linear table)
    function automatic logic [SIZE_W-1:0] tbl_size(input logic [IDX_W-1:0] idx);
        int unsigned i;
        int unsigned sz;
        i = int'(idx);
        if (i < REG16_START) begin
            sz = REG8_BASE + 8 * i;
        end
        else if (i < REG32_START) begin
            sz = REG16_BASE + 16 * (i - REG16_START);
        end
        else if (i < REG64_START) begin
            sz = REG32_BASE + 32 * (i - REG32_START);
        end
        else begin
            sz = REG64_BASE + 64 * (i - REG64_START);
        end
        return SIZE_W'(sz);
    endfunction

    // log2 of the gap between entry idx and entry idx-1
    function automatic logic [2:0] tbl_shift(input logic [IDX_W-1:0] idx);
        logic [2:0] sh;
        if (idx < IDX_W'(REG16_START)) begin
            sh = 3'd3;
        end
        else if (idx < IDX_W'(REG32_START)) begin
            sh = 3'd4;
        end
        else if (idx < IDX_W'(REG64_START)) begin
            sh = 3'd5;
        end
        else begin
            sh = 3'd6;
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tcbs_in_if.sv]
// Input channel: one transport block size word with valid/ready.
`default_nettype none

interface tcbs_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcbs_pkg::TBS_W-1:0]    block_size;

    modport source (output valid, output block_size, input ready);
    modport sink   (input valid, input block_size, output ready);
endinterface

`default_nettype wire

[hw/rtl/tcbs_out_if.sv]
// Output channel: one segmentation result word with valid/ready.
`default_nettype none

interface tcbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcbs_pkg::CNT_W-1:0]    num_blocks;
    logic [tcbs_pkg::CNT_W-1:0]    num_large;
    logic [tcbs_pkg::CNT_W-1:0]    num_small;
    logic [tcbs_pkg::SIZE_W-1:0]   size_large;
    logic [tcbs_pkg::SIZE_W-1:0]   size_small;
    logic [tcbs_pkg::IDX_W-1:0]    index_large;
    logic [tcbs_pkg::IDX_W-1:0]    index_small;
    logic [tcbs_pkg::FILL_W-1:0]   filler_bits;

    modport source (
        output valid, output num_blocks, output num_large, output num_small,
        output size_large, output size_small, output index_large,
        output index_small, output filler_bits, input ready
    );
    modport sink (
        input valid, input num_blocks, input num_large, input num_small,
        input size_large, input size_small, input index_large,
        input index_small, input filler_bits, output ready
    );
endinterface

`default_nettype wire

[hw/rtl/tcbs_div.sv]
// Shared restoring divider, one quotient bit per cycle, step count set at start.
`default_nettype none

module tcbs_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tcbs_pkg::div_ctrl_t             ctrl,
    input  wire logic [tcbs_pkg::NUM_W-1:0]      dividend,
    input  wire logic [tcbs_pkg::SIZE_W-1:0]     divisor,
    output tcbs_pkg::div_stat_t                  stat,
    output logic [tcbs_pkg::SIZE_W-1:0]          quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [tcbs_pkg::STEP_W-1:0]       cnt_reg;
    logic [tcbs_pkg::SIZE_W-1:0]       rem_reg;
    logic [tcbs_pkg::SIZE_W-1:0]       rem_next;
    logic [tcbs_pkg::NUM_W-1:0]        num_reg;
    logic [tcbs_pkg::SIZE_W-1:0]       quo_reg;
    logic [tcbs_pkg::SIZE_W-1:0]       dsr_reg;
    logic [tcbs_pkg::SIZE_W:0]         trial;
    logic                              fits;
    logic [tcbs_pkg::SHAMT_W-1:0]      lead_shift;

    // Trial subtract: bring in the next dividend bit
    always_comb
    begin
        trial    = {rem_reg, num_reg[tcbs_pkg::NUM_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? tcbs_pkg::SIZE_W'(trial - {1'b0, dsr_reg})
                        : trial[tcbs_pkg::SIZE_W-1:0];
        lead_shift = tcbs_pkg::SHAMT_W'(tcbs_pkg::NUM_W) - tcbs_pkg::SHAMT_W'(ctrl.steps);
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.steps;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tcbs_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the top bits of the dividend are below the divisor, so they seed the remainder
    always_ff @(posedge clk)
    begin
        if (ctrl.start) begin
            rem_reg <= tcbs_pkg::SIZE_W'(dividend >> ctrl.steps);
            num_reg <= dividend << lead_shift;
            quo_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[tcbs_pkg::NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[tcbs_pkg::SIZE_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // Checks
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !ctrl.start && cnt_reg == tcbs_pkg::STEP_W'(1) |=> done_reg)
        else $error("divider missed done after last step");

endmodule

`default_nettype wire

[hw/rtl/turbo_code_block_segmentation.sv]
// Sequencer: size zero goes straight to the result; a single code block skips the divisions.
// Several blocks use the shared divider: 8 steps for C, 13 steps for ceil(B'/C),
// and every nonzero size then runs an 8-step binary search of the interleaver size table.
// One word is in work at a time; the next word is taken once the sequencer is idle,
// even while the previous result still waits.
// Reset clears the sequencer and the output valid flag; no memory needs clearing.
`default_nettype none

module turbo_code_block_segmentation (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcbs_in_if.sink    tbs,
    tcbs_out_if.source seg
);

    tcbs_pkg::state_t                   state_reg;
    tcbs_pkg::state_t                   state_next;

    logic [tcbs_pkg::NUM_W-1:0]         b_reg;
    logic                               zero_reg;
    logic [tcbs_pkg::CNT_W-1:0]         c_reg;
    logic [tcbs_pkg::NUM_W-1:0]         bp_reg;
    logic [tcbs_pkg::NUM_W-1:0]         bp_next;
    logic [tcbs_pkg::SIZE_W-1:0]        need_reg;
    logic [tcbs_pkg::IDX_W-1:0]         pos_reg;
    logic [2:0]                         bit_reg;
    logic [tcbs_pkg::IDX_W-1:0]         i1_reg;
    logic [tcbs_pkg::SIZE_W-1:0]        k1_reg;
    logic [tcbs_pkg::NUM_W-1:0]         prod_reg;
    logic [tcbs_pkg::NUM_W-1:0]         diff_reg;
    logic                               out_valid_reg;

    logic [tcbs_pkg::CNT_W-1:0]         num_blocks_reg;
    logic [tcbs_pkg::CNT_W-1:0]         num_large_reg;
    logic [tcbs_pkg::CNT_W-1:0]         num_small_reg;
    logic [tcbs_pkg::SIZE_W-1:0]        size_large_reg;
    logic [tcbs_pkg::SIZE_W-1:0]        size_small_reg;
    logic [tcbs_pkg::IDX_W-1:0]         index_large_reg;
    logic [tcbs_pkg::IDX_W-1:0]         index_small_reg;
    logic [tcbs_pkg::FILL_W-1:0]        filler_bits_reg;

    tcbs_pkg::div_ctrl_t                div_ctrl;
    tcbs_pkg::div_stat_t                div_stat;
    logic [tcbs_pkg::NUM_W-1:0]         div_dividend;
    logic [tcbs_pkg::SIZE_W-1:0]        div_divisor;
    logic [tcbs_pkg::SIZE_W-1:0]        div_q;

    logic                               single;
    logic                               accept;
    logic                               load_out;
    logic [tcbs_pkg::IDX_W-1:0]         probe;
    logic                               probe_hit;
    logic [tcbs_pkg::IDX_W-1:0]         i1_sel;
    logic                               multi;
    logic [2:0]                         gap_sh;
    logic [tcbs_pkg::IDX_W-1:0]         i2_val;
    logic [tcbs_pkg::CNT_W-1:0]         c2_val;
    logic [tcbs_pkg::NUM_W-1:0]         gap_mask;

    // Shared divider
    tcbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign accept = tbs.valid && tbs.ready;
    assign single = (b_reg <= tcbs_pkg::NUM_W'(tcbs_pkg::MAX_BLOCK_LEN));

    // B' = B + 24*C once C is known
    assign bp_next = b_reg + tcbs_pkg::NUM_W'(c_reg) * tcbs_pkg::NUM_W'(tcbs_pkg::CRC_BITS);

    // Table search probe: count of entries below the needed size, built MSB first
    always_comb
    begin
        probe     = pos_reg + (tcbs_pkg::IDX_W'(1) << bit_reg);
        probe_hit = (probe <= tcbs_pkg::IDX_W'(tcbs_pkg::TABLE_ENTRIES))
                    && (tcbs_pkg::tbl_size(probe - 1'b1) < need_reg);
        i1_sel    = (pos_reg == tcbs_pkg::IDX_W'(tcbs_pkg::TABLE_ENTRIES))
                    ? tcbs_pkg::IDX_W'(tcbs_pkg::TABLE_ENTRIES - 1) : pos_reg;
    end

    // Final split: K+ - K- is a power of two, so C- and F come from shift and mask
    always_comb
    begin
        multi    = (c_reg != tcbs_pkg::CNT_W'(1)) && (i1_reg != '0);
        gap_sh   = tcbs_pkg::tbl_shift(i1_reg);
        gap_mask = (tcbs_pkg::NUM_W'(1) << gap_sh) - 1'b1;
        i2_val   = multi ? i1_reg - 1'b1 : '0;
        c2_val   = multi ? tcbs_pkg::CNT_W'(diff_reg >> gap_sh) : '0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcbs_pkg::ST_IDLE:
            begin
                if (accept) begin
                    state_next = tcbs_pkg::ST_PREP;
                end
            end
            tcbs_pkg::ST_PREP:
            begin
                if (zero_reg) begin
                    state_next = tcbs_pkg::ST_DONE;
                end
                else if (single) begin
                    state_next = tcbs_pkg::ST_SEARCH;
                end
                else begin
                    state_next = tcbs_pkg::ST_DIV_C;
                end
            end
            tcbs_pkg::ST_DIV_C:
            begin
                if (div_stat.done) begin
                    state_next = tcbs_pkg::ST_BP;
                end
            end
            tcbs_pkg::ST_BP:
            begin
                state_next = tcbs_pkg::ST_DIV_K;
            end
            tcbs_pkg::ST_DIV_K:
            begin
                if (div_stat.done) begin
                    state_next = tcbs_pkg::ST_SEARCH;
                end
            end
            tcbs_pkg::ST_SEARCH:
            begin
                if (bit_reg == '0) begin
                    state_next = tcbs_pkg::ST_MULT;
                end
            end
            tcbs_pkg::ST_MULT:
            begin
                state_next = tcbs_pkg::ST_DIFF;
            end
            tcbs_pkg::ST_DIFF:
            begin
                state_next = tcbs_pkg::ST_DONE;
            end
            tcbs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || seg.ready) begin
                    state_next = tcbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input ready, divider commands, output load
    always_comb
    begin
        tbs.ready      = 1'b0;
        load_out       = 1'b0;
        div_ctrl.start = 1'b0;
        div_ctrl.steps = tcbs_pkg::STEP_W'(tcbs_pkg::CNT_W);
        div_dividend   = b_reg + tcbs_pkg::NUM_W'(tcbs_pkg::SEG_LEN - 1);
        div_divisor    = tcbs_pkg::SIZE_W'(tcbs_pkg::SEG_LEN);
        unique case (state_reg)
            tcbs_pkg::ST_IDLE:
            begin
                tbs.ready = 1'b1;
            end
            tcbs_pkg::ST_PREP:
            begin
                // C = ceil(B / 6120), quotient fits in 8 bits
                div_ctrl.start = !zero_reg && !single;
            end
            tcbs_pkg::ST_BP:
            begin
                // ceil(B'/C) - 1 = (B' - 1) / C, quotient fits in 13 bits
                div_ctrl.start = 1'b1;
                div_ctrl.steps = tcbs_pkg::STEP_W'(tcbs_pkg::SIZE_W);
                div_dividend   = bp_next - 1'b1;
                div_divisor    = tcbs_pkg::SIZE_W'(c_reg);
            end
            tcbs_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || seg.ready;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= tcbs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end
            else if (seg.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tcbs_pkg::ST_IDLE:
            begin
                if (accept) begin
                    b_reg    <= tcbs_pkg::NUM_W'(tbs.block_size)
                                + tcbs_pkg::NUM_W'(tcbs_pkg::CRC_BITS);
                    zero_reg <= (tbs.block_size == '0);
                end
            end
            tcbs_pkg::ST_PREP:
            begin
                c_reg    <= tcbs_pkg::CNT_W'(1);
                bp_reg   <= b_reg;
                need_reg <= b_reg[tcbs_pkg::SIZE_W-1:0];
                pos_reg  <= '0;
                bit_reg  <= '1;
            end
            tcbs_pkg::ST_DIV_C:
            begin
                if (div_stat.done) begin
                    c_reg <= div_q[tcbs_pkg::CNT_W-1:0];
                end
            end
            tcbs_pkg::ST_BP:
            begin
                bp_reg <= bp_next;
            end
            tcbs_pkg::ST_DIV_K:
            begin
                if (div_stat.done) begin
                    need_reg <= div_q + 1'b1;
                    pos_reg  <= '0;
                    bit_reg  <= '1;
                end
            end
            tcbs_pkg::ST_SEARCH:
            begin
                if (probe_hit) begin
                    pos_reg <= probe;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            tcbs_pkg::ST_MULT:
            begin
                i1_reg   <= i1_sel;
                k1_reg   <= tcbs_pkg::tbl_size(i1_sel);
                prod_reg <= tcbs_pkg::NUM_W'(c_reg)
                            * tcbs_pkg::NUM_W'(tcbs_pkg::tbl_size(i1_sel));
            end
            tcbs_pkg::ST_DIFF:
            begin
                diff_reg <= prod_reg - bp_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out) begin
            if (zero_reg) begin
                num_blocks_reg  <= '0;
                num_large_reg   <= '0;
                num_small_reg   <= '0;
                size_large_reg  <= '0;
                size_small_reg  <= '0;
                index_large_reg <= '0;
                index_small_reg <= '0;
                filler_bits_reg <= '0;
            end
            else begin
                num_blocks_reg  <= c_reg;
                num_large_reg   <= c_reg - c2_val;
                num_small_reg   <= c2_val;
                size_large_reg  <= k1_reg;
                size_small_reg  <= multi ? tcbs_pkg::tbl_size(i2_val) : '0;
                index_large_reg <= i1_reg;
                index_small_reg <= i2_val;
                filler_bits_reg <= multi ? tcbs_pkg::FILL_W'(diff_reg & gap_mask)
                                         : diff_reg[tcbs_pkg::FILL_W-1:0];
            end
        end
    end

    assign seg.valid       = out_valid_reg;
    assign seg.num_blocks  = num_blocks_reg;
    assign seg.num_large   = num_large_reg;
    assign seg.num_small   = num_small_reg;
    assign seg.size_large  = size_large_reg;
    assign seg.size_small  = size_small_reg;
    assign seg.index_large = index_large_reg;
    assign seg.index_small = index_small_reg;
    assign seg.filler_bits = filler_bits_reg;

    // Checks
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tbs.ready |-> !div_stat.busy)
        else $error("input ready while divider busy");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tbs.ready)
        else $error("second word taken while one is in work");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == tcbs_pkg::ST_DIV_C || state_reg == tcbs_pkg::ST_DIV_K))
        else $error("divider result outside a wait state");
    a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
        seg.valid |-> tcbs_pkg::CNT_W'(seg.num_large + seg.num_small) == seg.num_blocks)
        else $error("block counts do not add up");
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        seg.valid && seg.num_blocks == '0 |-> seg.size_large == '0 && seg.filler_bits == '0)
        else $error("zero block count with nonzero size");

endmodule

`default_nettype wire
